/* design/icmp_echo_reply_builder_macros.svh */
// assertion macros used by the checker file
`ifndef ICMP_ECHO_REPLY_BUILDER_MACROS_SVH
`define ICMP_ECHO_REPLY_BUILDER_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define IERB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define IERB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/ierb_pkg.sv */
// types and constants for the icmp echo reply builder
package ierb_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] csum_t;
	typedef logic [15:0] byte_idx_t;
	typedef logic [31:0] ipv4_addr_t;
	typedef logic [4:0]  hdr_words_t;
	typedef logic [2:0]  req_flags_t;

	// header field values of an echo request
	localparam byte_t VER_IHL_V4_NOOPT = 8'h45;
	localparam byte_t PROTO_ICMP       = 8'h01;
	localparam byte_t ICMP_ECHO_REQ    = 8'h08;
	localparam csum_t CSUM_ALL_ONES    = 16'hffff;

	// byte offsets within the packet
	localparam byte_idx_t OFS_VER_IHL    = 16'd0;
	localparam byte_idx_t OFS_TLEN_HI    = 16'd2;
	localparam byte_idx_t OFS_TLEN_LO    = 16'd3;
	localparam byte_idx_t OFS_PROTO      = 16'd9;
	localparam byte_idx_t OFS_SRC_FIRST  = 16'd12;
	localparam byte_idx_t OFS_SRC_LAST   = 16'd15;
	localparam byte_idx_t OFS_DST_FIRST  = 16'd16;
	localparam byte_idx_t OFS_DST_LAST   = 16'd19;
	localparam byte_idx_t OFS_ICMP_TYPE  = 16'd20;
	localparam byte_idx_t OFS_ICMP_CODE  = 16'd21;
	localparam byte_idx_t OFS_CSUM_LO    = 16'd23;
	localparam byte_idx_t BYTE_IDX_MAX   = 16'hffff;
	localparam logic [16:0] MIN_PKT_BYTES = 17'd24;

	// header length handling
	localparam hdr_words_t MIN_HDR_WORDS = 5'd10;

	// request flag bits
	localparam int FLAG_VER   = 0;
	localparam int FLAG_PROTO = 1;
	localparam int FLAG_TYPE  = 2;
	localparam req_flags_t REQ_FLAGS_ALL = 3'b111;

endpackage

/* design/ierb_if.sv */
// valid/ready channels for packet bytes and reply results
interface ierb_byte_if;
	logic           valid;
	logic           ready;
	ierb_pkg::byte_t data_byte;
	logic           last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ierb_result_if;
	logic                  valid;
	logic                  ready;
	logic                  is_echo_request;
	logic                  checksum_ok;
	ierb_pkg::csum_t       reply_checksum;
	ierb_pkg::ipv4_addr_t  reply_source_ip;
	ierb_pkg::ipv4_addr_t  reply_dest_ip;
	logic                  truncated;

	modport source (
		output valid, output is_echo_request, output checksum_ok, output reply_checksum,
		output reply_source_ip, output reply_dest_ip, output truncated, input ready
	);
	modport sink (
		input valid, input is_echo_request, input checksum_ok, input reply_checksum,
		input reply_source_ip, input reply_dest_ip, input truncated, output ready
	);
endinterface

/* design/ierb_csum_add.sv */
// ones' complement 16-bit add with end-around carry
module ierb_csum_add (
	input  ierb_pkg::csum_t acc,
	input  ierb_pkg::csum_t word,
	output ierb_pkg::csum_t sum
);

	logic [16:0] raw;

	// fold the carry back into bit zero
	always_comb begin
		raw = {1'b0, acc} + {1'b0, word};
		sum = raw[15:0] + {15'd0, raw[16]};
	end

endmodule

/* design/icmp_echo_reply_builder.sv */
// Takes an IPv4 packet one byte per beat and returns one result beat per packet, on its last
// byte: echo request check, ICMP checksum check, swapped addresses, reply checksum and a
// truncation flag. A byte is taken every cycle unless input is held off; each byte other
// than a last one passes an input register and updates the running sums and capture
// registers in the next cycle. A last byte waits in the input register until the output
// register is free; the output register then loads the result. Input is held off only
// while a last byte sits in the input register and the previous result has not yet been taken.
module icmp_echo_reply_builder (
	input  logic clk,
	input  logic arst_n,
	ierb_byte_if.sink     pkt,
	ierb_result_if.source res
);

	// input register
	logic            valid_s1;
	ierb_pkg::byte_t data_s1;
	logic            last_s1;

	// per-packet state
	ierb_pkg::byte_idx_t  byte_idx_q;
	ierb_pkg::hdr_words_t hdr_words_q;
	logic [15:0]          tot_len_q;
	ierb_pkg::csum_t      sum_orig_q;
	ierb_pkg::csum_t      sum_reply_q;
	ierb_pkg::byte_t      high_byte_q;
	ierb_pkg::ipv4_addr_t src_addr_q;
	ierb_pkg::ipv4_addr_t dst_addr_q;
	ierb_pkg::req_flags_t req_flags_q;

	// result register
	logic                 res_valid_q;
	logic                 res_echo_q;
	logic                 res_csum_ok_q;
	ierb_pkg::csum_t      res_csum_q;
	ierb_pkg::ipv4_addr_t res_src_q;
	ierb_pkg::ipv4_addr_t res_dst_q;
	logic                 res_trunc_q;

	// next-state values
	ierb_pkg::hdr_words_t hdr_words_d;
	logic [15:0]          tot_len_d;
	ierb_pkg::csum_t      sum_orig_d;
	ierb_pkg::csum_t      sum_reply_d;
	ierb_pkg::ipv4_addr_t src_addr_d;
	ierb_pkg::ipv4_addr_t dst_addr_d;
	ierb_pkg::req_flags_t req_flags_d;
	ierb_pkg::csum_t      word_orig;
	ierb_pkg::csum_t      word_reply;
	ierb_pkg::csum_t      sum_orig_add;
	ierb_pkg::csum_t      sum_reply_add;
	ierb_pkg::hdr_words_t hw_raw;
	logic                 in_range;
	logic [16:0]          byte_count;
	logic                 trunc_d;

	logic out_free;
	logic advance;
	logic process;

	// handshake and stage advance
	assign out_free = !res_valid_q || res.ready;
	assign advance  = !valid_s1 || !last_s1 || out_free;
	assign process  = valid_s1 && advance;
	assign pkt.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pkt.valid) begin
			data_s1 <= pkt.data_byte;
			last_s1 <= pkt.last_byte;
		end
	end

	// header capture
	always_comb begin
		hw_raw      = {data_s1[3:0], 1'b0};
		hdr_words_d = hdr_words_q;
		tot_len_d   = tot_len_q;
		req_flags_d = req_flags_q;
		src_addr_d  = src_addr_q;
		dst_addr_d  = dst_addr_q;
		if (byte_idx_q == ierb_pkg::OFS_VER_IHL) begin
			hdr_words_d = (hw_raw < ierb_pkg::MIN_HDR_WORDS) ? ierb_pkg::MIN_HDR_WORDS : hw_raw;
			if (data_s1 == ierb_pkg::VER_IHL_V4_NOOPT) begin
				req_flags_d[ierb_pkg::FLAG_VER] = 1'b1;
			end
		end
		if (byte_idx_q == ierb_pkg::OFS_TLEN_HI) begin
			tot_len_d = {data_s1, 8'd0};
		end
		if (byte_idx_q == ierb_pkg::OFS_TLEN_LO) begin
			tot_len_d = {tot_len_q[15:8], data_s1};
		end
		if (byte_idx_q == ierb_pkg::OFS_PROTO && data_s1 == ierb_pkg::PROTO_ICMP) begin
			req_flags_d[ierb_pkg::FLAG_PROTO] = 1'b1;
		end
		if (byte_idx_q == ierb_pkg::OFS_ICMP_TYPE && data_s1 == ierb_pkg::ICMP_ECHO_REQ) begin
			req_flags_d[ierb_pkg::FLAG_TYPE] = 1'b1;
		end
		if (byte_idx_q inside {[ierb_pkg::OFS_SRC_FIRST : ierb_pkg::OFS_SRC_LAST]}) begin
			src_addr_d = {src_addr_q[23:0], data_s1};
		end
		if (byte_idx_q inside {[ierb_pkg::OFS_DST_FIRST : ierb_pkg::OFS_DST_LAST]}) begin
			dst_addr_d = {dst_addr_q[23:0], data_s1};
		end
	end

	// words for the two running sums
	always_comb begin
		word_orig  = {high_byte_q, data_s1};
		word_reply = word_orig;
		if (byte_idx_q == ierb_pkg::OFS_ICMP_CODE) begin
			word_reply = {8'd0, data_s1};
		end
		if (byte_idx_q == ierb_pkg::OFS_CSUM_LO) begin
			word_reply = 16'd0;
		end
		in_range = byte_idx_q[0]
			&& (byte_idx_q[15:1] >= {10'd0, hdr_words_q})
			&& (byte_idx_q[15:1] < tot_len_q[15:1]);
	end

	ierb_csum_add u_add_orig (
		.acc  (sum_orig_q),
		.word (word_orig),
		.sum  (sum_orig_add)
	);

	ierb_csum_add u_add_reply (
		.acc  (sum_reply_q),
		.word (word_reply),
		.sum  (sum_reply_add)
	);

	// sums and truncation check
	always_comb begin
		sum_orig_d  = in_range ? sum_orig_add : sum_orig_q;
		sum_reply_d = in_range ? sum_reply_add : sum_reply_q;
		byte_count  = {1'b0, byte_idx_q} + 17'd1;
		trunc_d     = (byte_count < ierb_pkg::MIN_PKT_BYTES) || (byte_count < {1'b0, tot_len_d});
	end

	// packet state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q  <= '0;
			hdr_words_q <= '0;
			tot_len_q   <= '0;
			sum_orig_q  <= '0;
			sum_reply_q <= '0;
			high_byte_q <= '0;
			src_addr_q  <= '0;
			dst_addr_q  <= '0;
			req_flags_q <= '0;
		end else if (process) begin
			if (last_s1) begin
				byte_idx_q  <= '0;
				hdr_words_q <= '0;
				tot_len_q   <= '0;
				sum_orig_q  <= '0;
				sum_reply_q <= '0;
				high_byte_q <= '0;
				src_addr_q  <= '0;
				dst_addr_q  <= '0;
				req_flags_q <= '0;
			end else begin
				if (byte_idx_q != ierb_pkg::BYTE_IDX_MAX) begin
					byte_idx_q <= byte_idx_q + 16'd1;
				end
				hdr_words_q <= hdr_words_d;
				tot_len_q   <= tot_len_d;
				sum_orig_q  <= sum_orig_d;
				sum_reply_q <= sum_reply_d;
				if (!byte_idx_q[0]) begin
					high_byte_q <= data_s1;
				end
				src_addr_q  <= src_addr_d;
				dst_addr_q  <= dst_addr_d;
				req_flags_q <= req_flags_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (process && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && last_s1) begin
			res_echo_q    <= (req_flags_d == ierb_pkg::REQ_FLAGS_ALL);
			res_csum_ok_q <= (sum_orig_d == ierb_pkg::CSUM_ALL_ONES);
			res_csum_q    <= ~sum_reply_d;
			res_src_q     <= dst_addr_d;
			res_dst_q     <= src_addr_d;
			res_trunc_q   <= trunc_d;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.is_echo_request = res_echo_q;
	assign res.checksum_ok     = res_csum_ok_q;
	assign res.reply_checksum  = res_csum_q;
	assign res.reply_source_ip = res_src_q;
	assign res.reply_dest_ip   = res_dst_q;
	assign res.truncated       = res_trunc_q;

endmodule

/* design/ierb_checker.sv */
// port-level checks for the icmp echo reply builder, bound to the top level
`include "icmp_echo_reply_builder_macros.svh"

module ierb_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input ierb_pkg::csum_t      out_csum,
	input ierb_pkg::ipv4_addr_t out_src,
	input ierb_pkg::ipv4_addr_t out_dst
);

	// a result beat stays up until taken
	`IERB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")

	// a stalled result keeps its payload
	`IERB_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_csum) && $stable(out_src) && $stable(out_dst), "result payload changed while stalled")

	// with an empty output register the byte input is never held off
	`IERB_ASSERT_ALWAYS(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with no pending result")

	// a new result is preceded by a taken byte beat
	`IERB_ASSERT(a_result_has_byte, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result appeared without an input beat")

endmodule

bind icmp_echo_reply_builder ierb_checker u_ierb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pkt.valid),
	.in_ready  (pkt.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_csum  (res.reply_checksum),
	.out_src   (res.reply_source_ip),
	.out_dst   (res.reply_dest_ip)
);
